>>> rtl/srtwm_pkg.sv
// ----------------------------------------------------------------------------
// srtwm_pkg: shared types and constants of the world matrix builder
// Holds the beat structs of both channels, the fixed-point formats, the
// CORDIC angle constants and the Q30 rounding helper.
// ----------------------------------------------------------------------------
package srtwm_pkg;

    // Widths of the internal fixed-point words.
    localparam int ANGLE_W = 16;
    localparam int Z_W     = 36;   // Q30 angle, covers a 16-bit Q4.12 input
    localparam int X_W     = 34;   // CORDIC x/y datapath
    localparam int SC_W    = 32;   // Q30 sine, cosine and rotation entries
    localparam int PR_W    = 64;   // Q60 products
    localparam int M_W     = 24;   // matrix element width

    // Angle constants in Q30.
    localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [X_W-1:0] GAIN_Q30    = 34'sd652032874;

    // Saturation limits of a matrix element.
    localparam logic signed [M_W-1:0] M_MAX = 24'sd8388607;
    localparam logic signed [M_W-1:0] M_MIN = -24'sd8388608;

    // One input beat.
    typedef struct packed {
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } t_in_item;

    // One output beat.
    typedef struct packed {
        logic signed [23:0] m00;
        logic signed [23:0] m01;
        logic signed [23:0] m02;
        logic signed [23:0] m10;
        logic signed [23:0] m11;
        logic signed [23:0] m12;
        logic signed [23:0] m20;
        logic signed [23:0] m21;
        logic signed [23:0] m22;
        logic signed [31:0] out_tx;
        logic signed [31:0] out_ty;
        logic signed [31:0] out_tz;
    } t_out_item;

    // Arctangent of 2^-idx in Q30, rounded.
    function automatic logic signed [Z_W-1:0] srtwm_atan(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 36'sd843314857;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043837;
            3:       v = 36'sd133525159;
            4:       v = 36'sd67021687;
            5:       v = 36'sd33543516;
            6:       v = 36'sd16775851;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194283;
            9:       v = 36'sd2097149;
            10:      v = 36'sd1048576;
            11:      v = 36'sd524288;
            12:      v = 36'sd262144;
            13:      v = 36'sd131072;
            14:      v = 36'sd65536;
            15:      v = 36'sd32768;
            16:      v = 36'sd16384;
            17:      v = 36'sd8192;
            18:      v = 36'sd4096;
            19:      v = 36'sd2048;
            20:      v = 36'sd1024;
            21:      v = 36'sd512;
            22:      v = 36'sd256;
            23:      v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q60 value half up to Q30.
    function automatic logic signed [SC_W-1:0] srtwm_rnd30(input logic signed [PR_W:0] v);
        logic signed [PR_W:0] t;
        t = v + (65'sd1 <<< 29);
        return t[SC_W+29:30];
    endfunction

endpackage

>>> rtl/srtwm_cordic.sv
// ----------------------------------------------------------------------------
// srtwm_cordic: pipelined sine and cosine of one angle
// Wraps the Q4.12 angle into [-pi, pi], folds it into [-pi/2, pi/2], runs
// one CORDIC rotation per register stage and restores the sign at the end.
// Every step is registered and advances only while i_en is high.
// ----------------------------------------------------------------------------
module srtwm_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [srtwm_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [srtwm_pkg::SC_W-1:0]    o_sin,
    output logic signed [srtwm_pkg::SC_W-1:0]    o_cos
);
    import srtwm_pkg::*;

    logic signed [Z_W-1:0] n_z0;
    logic signed [Z_W-1:0] r_zw;
    logic signed [X_W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [X_W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [Z_W-1:0] r_z [CORDIC_STAGES+1];
    logic                  r_neg [CORDIC_STAGES+1];
    logic signed [X_W-1:0] n_sin;
    logic signed [X_W-1:0] n_cos;

    // Angle into Q30.
    assign n_z0 = {{(Z_W-ANGLE_W-18){i_angle[ANGLE_W-1]}}, i_angle, 18'b0};

    // One wrap by a full turn is enough for any 16-bit input.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_z0 > PI_Q30) begin
                r_zw <= n_z0 - TWO_PI_Q30;
            end else if (n_z0 < -PI_Q30) begin
                r_zw <= n_z0 + TWO_PI_Q30;
            end else begin
                r_zw <= n_z0;
            end
        end
    end

    // Fold into the right half plane; sine and cosine flip sign later.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            if (r_zw > HALF_PI_Q30) begin
                r_z[0]   <= r_zw - PI_Q30;
                r_neg[0] <= 1'b1;
            end else if (r_zw < -HALF_PI_Q30) begin
                r_z[0]   <= r_zw + PI_Q30;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= r_zw;
                r_neg[0] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[gi+1] <= r_neg[gi];
                if (!r_z[gi][Z_W-1]) begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] - srtwm_atan(gi);
                end else begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] + srtwm_atan(gi);
                end
            end
        end
    end

    // Undo the fold.
    assign n_cos = r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
    assign n_sin = r_neg[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_cos[SC_W-1:0];
            o_sin <= n_sin[SC_W-1:0];
        end
    end

endmodule

>>> rtl/srt_world_matrix_builder.sv
// ----------------------------------------------------------------------------
// srt_world_matrix_builder: scale, rotate, translate world matrix
// Builds the row-vector world matrix S*Rz*Rx*Ry*T of one object.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, i_item, o_stall) takes one beat of scale,
//   Euler angles and translation. The output channel (o_valid, o_item,
//   i_stall) gives the nine saturated rotation-scale elements and the
//   translation row. A beat moves when valid is high and stall is low.
//   Three CORDIC pipelines run side by side, then six matrix stages
//   follow, each holding one rank of 32x32 or 16x32 multipliers or the
//   rounding after them.
//   Throughput is one beat per cycle; the whole pipeline advances as one.
//   When the receiver stalls with a result waiting, every stage holds and
//   o_stall rises in the same cycle, so nothing is lost or repeated.
//   Reset clears the valid bits of all stages; the datapath needs none.
// ----------------------------------------------------------------------------
module srt_world_matrix_builder #(
    parameter int CORDIC_STAGES = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  srtwm_pkg::t_in_item  i_item,
    output logic                 o_stall,
    output logic                 o_valid,
    output srtwm_pkg::t_out_item o_item,
    input  logic                 i_stall
);
    import srtwm_pkg::*;

    localparam int CL  = CORDIC_STAGES + 3;
    localparam int LAT = CL + 6;
    localparam int SH  = 38 - OUT_FRAC_BITS;
    localparam int SP_W = 16 + SC_W;

    logic                  w_en;
    logic                  r_vld [LAT];
    t_in_item              r_dly [CL];
    logic signed [SC_W-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    logic signed [PR_W-1:0] r1_p [4];
    logic signed [SC_W-1:0] r1_cz, r1_sz, r1_cx, r1_sx, r1_cy, r1_sy;
    t_in_item               r1_item;
    logic signed [SC_W-1:0] r2_a [3][3];
    logic signed [SC_W-1:0] r2_cy, r2_sy;
    t_in_item               r2_item;
    logic signed [PR_W-1:0] r3_q [3][4];
    logic signed [SC_W-1:0] r3_a1 [3];
    t_in_item               r3_item;
    logic signed [SC_W-1:0] r4_r [3][3];
    t_in_item               r4_item;
    logic signed [15:0]     w4_sc [3];
    logic signed [SP_W-1:0] r5_p [3][3];
    t_in_item               r5_item;
    logic signed [SP_W:0]   n_v [3][3];
    logic signed [M_W-1:0]  n_m [3][3];
    logic signed [M_W-1:0]  r6_m [3][3];
    t_in_item               r6_item;

    // Whole pipeline holds while a finished beat waits.
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    // Valid bits follow the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Scale and translation wait alongside the CORDIC pipelines.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= i_item;
            for (int k = 1; k < CL; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // Sine and cosine of the three angles.
    srtwm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_item.angle_x), .o_sin(w_sx), .o_cos(w_cx)
    );
    srtwm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_item.angle_y), .o_sin(w_sy), .o_cos(w_cy)
    );
    srtwm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_item.angle_z), .o_sin(w_sz), .o_cos(w_cz)
    );

    // Products of Rz*Rx.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p[0] <= PR_W'(w_sz) * PR_W'(w_cx);
            r1_p[1] <= PR_W'(w_sz) * PR_W'(w_sx);
            r1_p[2] <= PR_W'(w_cz) * PR_W'(w_cx);
            r1_p[3] <= PR_W'(w_cz) * PR_W'(w_sx);
            r1_cz   <= w_cz;
            r1_sz   <= w_sz;
            r1_cx   <= w_cx;
            r1_sx   <= w_sx;
            r1_cy   <= w_cy;
            r1_sy   <= w_sy;
            r1_item <= r_dly[CL-1];
        end
    end

    // A = Rz*Rx, rounded to Q30.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a[0][0] <= r1_cz;
            r2_a[0][1] <= srtwm_rnd30({r1_p[0][PR_W-1], r1_p[0]});
            r2_a[0][2] <= srtwm_rnd30({r1_p[1][PR_W-1], r1_p[1]});
            r2_a[1][0] <= -r1_sz;
            r2_a[1][1] <= srtwm_rnd30({r1_p[2][PR_W-1], r1_p[2]});
            r2_a[1][2] <= srtwm_rnd30({r1_p[3][PR_W-1], r1_p[3]});
            r2_a[2][0] <= '0;
            r2_a[2][1] <= -r1_sx;
            r2_a[2][2] <= r1_cx;
            r2_cy      <= r1_cy;
            r2_sy      <= r1_sy;
            r2_item    <= r1_item;
        end
    end

    // Products of A*Ry; the middle column passes through.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_q[i][0] <= PR_W'(r2_a[i][0]) * PR_W'(r2_cy);
                r3_q[i][1] <= PR_W'(r2_a[i][2]) * PR_W'(r2_sy);
                r3_q[i][2] <= PR_W'(r2_a[i][0]) * PR_W'(r2_sy);
                r3_q[i][3] <= PR_W'(r2_a[i][2]) * PR_W'(r2_cy);
                r3_a1[i]   <= r2_a[i][1];
            end
            r3_item <= r2_item;
        end
    end

    // R = A*Ry, exact sums rounded to Q30.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_r[i][0] <= srtwm_rnd30({r3_q[i][0][PR_W-1], r3_q[i][0]}
                                        + {r3_q[i][1][PR_W-1], r3_q[i][1]});
                r4_r[i][1] <= r3_a1[i];
                r4_r[i][2] <= srtwm_rnd30({r3_q[i][3][PR_W-1], r3_q[i][3]}
                                        - {r3_q[i][2][PR_W-1], r3_q[i][2]});
            end
            r4_item <= r3_item;
        end
    end

    // Row scale factors.
    assign w4_sc[0] = r4_item.scale_x;
    assign w4_sc[1] = r4_item.scale_y;
    assign w4_sc[2] = r4_item.scale_z;

    // Scale each row.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_p[i][j] <= SP_W'(w4_sc[i]) * SP_W'(r4_r[i][j]);
                end
            end
            r5_item <= r4_item;
        end
    end

    // Round to the output format and saturate.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_v[i][j] = ($signed({r5_p[i][j][SP_W-1], r5_p[i][j]})
                            + ((SP_W+1)'(1) <<< (SH-1))) >>> SH;
                if (n_v[i][j] > (SP_W+1)'(M_MAX)) begin
                    n_m[i][j] = M_MAX;
                end else if (n_v[i][j] < (SP_W+1)'(M_MIN)) begin
                    n_m[i][j] = M_MIN;
                end else begin
                    n_m[i][j] = n_v[i][j][M_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_m    <= n_m;
            r6_item <= r5_item;
        end
    end

    // Output beat.
    assign o_item.m00    = r6_m[0][0];
    assign o_item.m01    = r6_m[0][1];
    assign o_item.m02    = r6_m[0][2];
    assign o_item.m10    = r6_m[1][0];
    assign o_item.m11    = r6_m[1][1];
    assign o_item.m12    = r6_m[1][2];
    assign o_item.m20    = r6_m[2][0];
    assign o_item.m21    = r6_m[2][1];
    assign o_item.m22    = r6_m[2][2];
    assign o_item.out_tx = r6_item.move_x;
    assign o_item.out_ty = r6_item.move_y;
    assign o_item.out_tz = r6_item.move_z;

endmodule

>>> tb/srtwm_matrix_checker.sv
// ----------------------------------------------------------------------------
// srtwm_matrix_checker: beat monitor and world matrix predictor
// Watches both channels of the world matrix builder, computes the expected
// matrix of every accepted input beat and compares it with each output beat.
// ----------------------------------------------------------------------------
module srtwm_matrix_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  srtwm_pkg::t_in_item  i_item,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  srtwm_pkg::t_out_item i_out_item,
    input  logic                 i_out_stall,
    output int                   o_fail_count,
    output int                   o_pending
);
    import srtwm_pkg::*;

    localparam int  N_STAGES  = 16;
    localparam int  FRAC_OUT  = 16;
    localparam longint CORDIC_K = 64'sd652032874;
    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam longint ELEM_MAX = 64'sd8388607;
    localparam longint ELEM_MIN = -64'sd8388608;

    longint    arctan_q30 [N_STAGES];
    longint    pi_val;
    t_out_item matrix_queue [$];
    int        fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = matrix_queue.size();

    // Half-up rounding with an arithmetic shift.
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Arctangent of 1/n in Q60 by the alternating series.
    function automatic longint arctan_recip(input longint unsigned n);
        longint unsigned p, nn, k;
        longint sum, term;
        p = (64'd1 << 60) / n;
        nn = n * n;
        sum = 0;
        k = 0;
        while (p != 0) begin
            term = longint'(p / (2 * k + 1));
            sum += k[0] ? -term : term;
            p = p / nn;
            k++;
        end
        return sum;
    endfunction

    // Range reduction followed by the rotation-mode CORDIC.
    function automatic void sin_cos(input logic signed [15:0] ang, output longint sn,
                                    output longint cs);
        longint z, x, y, dx, dy, half;
        bit     flip;
        z = longint'(ang) * 262144;
        x = CORDIC_K;
        y = 0;
        half = pi_val >>> 1;
        flip = 0;
        while (z > pi_val) z -= 2 * pi_val;
        while (z < -pi_val) z += 2 * pi_val;
        if (z > half) begin
            z -= pi_val;
            flip = 1;
        end else if (z < -half) begin
            z += pi_val;
            flip = 1;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q30[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q30[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // Full S*Rz*Rx*Ry*T prediction for one input beat.
    function automatic t_out_item build_world(input t_in_item it);
        longint    sx, cx, sy, cy, sz, cz, acc, v;
        longint    rz [3][3], rx [3][3], ry [3][3], am [3][3], rm [3][3];
        longint    scl [3];
        t_out_item res;
        logic signed [23:0] elem [9];
        sin_cos(it.angle_x, sx, cx);
        sin_cos(it.angle_y, sy, cy);
        sin_cos(it.angle_z, sz, cz);
        scl[0] = it.scale_x;
        scl[1] = it.scale_y;
        scl[2] = it.scale_z;
        rz = '{'{cz, sz, 0}, '{-sz, cz, 0}, '{0, 0, ONE_Q30}};
        rx = '{'{ONE_Q30, 0, 0}, '{0, cx, sx}, '{0, -sx, cx}};
        ry = '{'{cy, 0, -sy}, '{0, ONE_Q30, 0}, '{sy, 0, cy}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += rz[i][k] * rx[k][j];
                am[i][j] = rnd_shift(acc, 30);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += am[i][k] * ry[k][j];
                rm[i][j] = rnd_shift(acc, 30);
                v = rnd_shift(scl[i] * rm[i][j], 38 - FRAC_OUT);
                if (v > ELEM_MAX) v = ELEM_MAX;
                if (v < ELEM_MIN) v = ELEM_MIN;
                elem[i * 3 + j] = v[23:0];
            end
        res.m00 = elem[0]; res.m01 = elem[1]; res.m02 = elem[2];
        res.m10 = elem[3]; res.m11 = elem[4]; res.m12 = elem[5];
        res.m20 = elem[6]; res.m21 = elem[7]; res.m22 = elem[8];
        res.out_tx = it.move_x;
        res.out_ty = it.move_y;
        res.out_tz = it.move_z;
        return res;
    endfunction

    // One field comparison with a report on mismatch.
    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, fname,
                     $signed(exp_v), $signed(act_v));
            fail_cnt++;
        end
    endtask

    // Constant tables, built once.
    initial begin
        longint q;
        fail_cnt = 0;
        q = arctan_recip(2) + arctan_recip(3);
        arctan_q30[0] = rnd_shift(q, 30);
        pi_val = rnd_shift(q * 4, 30);
        for (int i = 1; i < N_STAGES; i++)
            arctan_q30[i] = rnd_shift(arctan_recip(64'd1 << i), 30);
    end

    // Predict on each input beat, compare on each output beat.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                matrix_queue.push_back(build_world(i_item));
            if (i_out_valid && !i_out_stall) begin
                if (matrix_queue.size() == 0) begin
                    $display("%0t: output beat with no expected matrix", $realtime);
                    fail_cnt++;
                end else begin
                    want = matrix_queue.pop_front();
                    check_field("m00", 32'(want.m00), 32'(i_out_item.m00));
                    check_field("m01", 32'(want.m01), 32'(i_out_item.m01));
                    check_field("m02", 32'(want.m02), 32'(i_out_item.m02));
                    check_field("m10", 32'(want.m10), 32'(i_out_item.m10));
                    check_field("m11", 32'(want.m11), 32'(i_out_item.m11));
                    check_field("m12", 32'(want.m12), 32'(i_out_item.m12));
                    check_field("m20", 32'(want.m20), 32'(i_out_item.m20));
                    check_field("m21", 32'(want.m21), 32'(i_out_item.m21));
                    check_field("m22", 32'(want.m22), 32'(i_out_item.m22));
                    check_field("out_tx", want.out_tx, i_out_item.out_tx);
                    check_field("out_ty", want.out_ty, i_out_item.out_ty);
                    check_field("out_tz", want.out_tz, i_out_item.out_tz);
                end
            end
        end
    end

endmodule

>>> tb/tb_srt_world_matrix_builder.sv
// ----------------------------------------------------------------------------
// tb_srt_world_matrix_builder: regression bench of the world matrix builder
// Drives directed and random object transforms with random idle and stall
// cycles, one long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_srt_world_matrix_builder;
    import srtwm_pkg::*;

    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_CAP  = 300000;
    localparam int CALM_START = 1500;
    localparam int CALM_END   = 2300;
    localparam int HOLD_START = 800;
    localparam int HOLD_LEN   = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;
    int        fail_count;
    int        pending;
    int        cycle = 0;

    always #5 clk = ~clk;

    srt_world_matrix_builder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_stall (in_stall),
        .o_valid (out_valid),
        .o_item  (out_item),
        .i_stall (out_stall)
    );

    srtwm_matrix_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .i_item       (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Cycle counter and run limit.
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_CAP) begin
            $display("srt_world_matrix_builder regression: fail");
            $finish;
        end
    end

    // Receiver stalls at random, with a calm stretch and one long hold-off.
    always @(posedge clk) begin
        if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN)
            out_stall <= 1'b1;
        else if (cycle >= CALM_START && cycle < CALM_END)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 22);
    end

    function automatic bit want_idle();
        if (cycle >= CALM_START && cycle < CALM_END)
            return 0;
        return $urandom_range(99) < 22;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.move_x = $urandom;
        it.move_y = $urandom;
        it.move_z = $urandom;
        if ($urandom_range(3) == 0) begin
            {it.scale_x, it.scale_y} = $urandom;
            {it.scale_z, it.angle_x} = $urandom;
            {it.angle_y, it.angle_z} = $urandom;
        end else begin
            // Typical objects: scales within a few units, angles within one turn either way.
            it.scale_x = 16'($signed($urandom_range(2048)) - 1024);
            it.scale_y = 16'($signed($urandom_range(2048)) - 1024);
            it.scale_z = 16'($signed($urandom_range(2048)) - 1024);
            it.angle_x = 16'($signed($urandom_range(51472)) - 25736);
            it.angle_y = 16'($signed($urandom_range(51472)) - 25736);
            it.angle_z = 16'($signed($urandom_range(51472)) - 25736);
        end
        return it;
    endfunction

    function automatic t_in_item make_item(input logic [15:0] sc, input logic [15:0] ax,
                                           input logic [15:0] ay, input logic [15:0] az,
                                           input logic [31:0] mv);
        t_in_item it;
        it.scale_x = sc; it.scale_y = sc; it.scale_z = sc;
        it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
        it.move_x = mv; it.move_y = ~mv; it.move_z = mv ^ 32'h5A5A_A5A5;
        return it;
    endfunction

    // Offer one input beat and hold it until accepted.
    task automatic send_beat(input t_in_item it);
        if (want_idle()) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (want_idle());
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(negedge clk);
            if (!in_stall) break;
        end
        @(posedge clk);
    endtask

    initial begin
        t_in_item dir_list [$];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, extremes of scale, angle and translation,
        // quarter turns, wrap-around angles, mirroring and saturation.
        dir_list.push_back(make_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0));
        dir_list.push_back(make_item(16'sd256, 16'sd0, 16'sd0, 16'sd0, 32'h0001_0000));
        dir_list.push_back(make_item(-16'sd256, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_0000));
        dir_list.push_back(make_item(16'h7FFF, 16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFF));
        dir_list.push_back(make_item(16'h8000, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000));
        dir_list.push_back(make_item(16'h7FFF, 16'sd3217, 16'sd3217, 16'sd3217, 32'h0));
        dir_list.push_back(make_item(16'h8000, -16'sd3217, 16'sd1000, -16'sd2000, 32'h0));
        dir_list.push_back(make_item(16'sd256, 16'sd6434, 16'sd0, 16'sd0, 32'h1234_5678));
        dir_list.push_back(make_item(16'sd256, 16'sd0, 16'sd6434, 16'sd0, 32'h1234_5678));
        dir_list.push_back(make_item(16'sd256, 16'sd0, 16'sd0, 16'sd6434, 32'h1234_5678));
        dir_list.push_back(make_item(16'sd256, -16'sd6434, -16'sd6434, -16'sd6434, 32'h0));
        dir_list.push_back(make_item(16'sd256, 16'sd12868, 16'sd12868, 16'sd12868, 32'h0));
        dir_list.push_back(make_item(16'sd256, -16'sd12868, 16'sd12867, 16'sd6435, 32'h0));
        dir_list.push_back(make_item(16'sd256, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF));
        dir_list.push_back(make_item(16'sd256, 16'h8000, 16'h8000, 16'h8000, 32'h0));
        dir_list.push_back(make_item(16'sd512, 16'sd25736, -16'sd25736, 16'sd19302, 32'h0));
        dir_list.push_back(make_item(16'h7FFF, 16'h7FFF, 16'h8000, 16'sd1, 32'h0));
        dir_list.push_back(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        dir_list.push_back(make_item(16'sd1, 16'sd1, 16'sd1, 16'sd1, 32'h1));
        dir_list.push_back(make_item(16'sd32, 16'sd4096, 16'sd8192, -16'sd4096, 32'hA5A5_5A5A));
        foreach (dir_list[i]) send_beat(dir_list[i]);

        for (int n = 0; n < N_RANDOM; n++) send_beat(rand_item());
        in_valid <= 1'b0;

        // Drain, then watch a little longer for stray beats.
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("srt_world_matrix_builder regression: pass");
        else
            $display("srt_world_matrix_builder regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/srtwm_pkg.sv
rtl/srtwm_cordic.sv
rtl/srt_world_matrix_builder.sv
tb/srtwm_matrix_checker.sv
tb/tb_srt_world_matrix_builder.sv
